// ===== rtl/arp_pkg.sv =====
`default_nettype none
package arp_pkg;

  localparam int unsigned FUNC_W  = 10;
  localparam int unsigned WORD_W  = 64;
  localparam int unsigned INS_W   = 32;
  localparam int unsigned PAGE_W  = 12;
  localparam int unsigned HI_W    = WORD_W - PAGE_W;
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Relocation type numbers.
  localparam logic [FUNC_W-1:0] R_NONE               = 10'd0;
  localparam logic [FUNC_W-1:0] R_ABS64              = 10'd257;
  localparam logic [FUNC_W-1:0] R_ABS32              = 10'd258;
  localparam logic [FUNC_W-1:0] R_ABS16              = 10'd259;
  localparam logic [FUNC_W-1:0] R_PREL64             = 10'd260;
  localparam logic [FUNC_W-1:0] R_PREL32             = 10'd261;
  localparam logic [FUNC_W-1:0] R_PREL16             = 10'd262;
  localparam logic [FUNC_W-1:0] R_MOVW_UABS_G0       = 10'd263;
  localparam logic [FUNC_W-1:0] R_MOVW_UABS_G0_NC    = 10'd264;
  localparam logic [FUNC_W-1:0] R_MOVW_UABS_G1       = 10'd265;
  localparam logic [FUNC_W-1:0] R_MOVW_UABS_G1_NC    = 10'd266;
  localparam logic [FUNC_W-1:0] R_MOVW_UABS_G2       = 10'd267;
  localparam logic [FUNC_W-1:0] R_MOVW_UABS_G2_NC    = 10'd268;
  localparam logic [FUNC_W-1:0] R_MOVW_UABS_G3       = 10'd269;
  localparam logic [FUNC_W-1:0] R_MOVW_SABS_G0       = 10'd270;
  localparam logic [FUNC_W-1:0] R_MOVW_SABS_G1       = 10'd271;
  localparam logic [FUNC_W-1:0] R_MOVW_SABS_G2       = 10'd272;
  localparam logic [FUNC_W-1:0] R_LD_PREL_LO19       = 10'd273;
  localparam logic [FUNC_W-1:0] R_ADR_PREL_LO21      = 10'd274;
  localparam logic [FUNC_W-1:0] R_ADR_PREL_PG_HI21   = 10'd275;
  localparam logic [FUNC_W-1:0] R_ADR_PREL_PG_HI21NC = 10'd276;
  localparam logic [FUNC_W-1:0] R_ADD_ABS_LO12_NC    = 10'd277;
  localparam logic [FUNC_W-1:0] R_LDST8_ABS_LO12_NC  = 10'd278;
  localparam logic [FUNC_W-1:0] R_JUMP26             = 10'd282;
  localparam logic [FUNC_W-1:0] R_CALL26             = 10'd283;
  localparam logic [FUNC_W-1:0] R_LDST16_ABS_LO12_NC = 10'd284;
  localparam logic [FUNC_W-1:0] R_LDST32_ABS_LO12_NC = 10'd285;
  localparam logic [FUNC_W-1:0] R_LDST64_ABS_LO12_NC = 10'd286;
  localparam logic [FUNC_W-1:0] R_MOVW_PREL_G0       = 10'd287;
  localparam logic [FUNC_W-1:0] R_MOVW_PREL_G0_NC    = 10'd288;
  localparam logic [FUNC_W-1:0] R_MOVW_PREL_G1       = 10'd289;
  localparam logic [FUNC_W-1:0] R_MOVW_PREL_G1_NC    = 10'd290;
  localparam logic [FUNC_W-1:0] R_MOVW_PREL_G2       = 10'd291;
  localparam logic [FUNC_W-1:0] R_MOVW_PREL_G2_NC    = 10'd292;
  localparam logic [FUNC_W-1:0] R_MOVW_PREL_G3       = 10'd293;
  localparam logic [FUNC_W-1:0] R_LDST128_ABS_LO12_NC = 10'd299;

  // Write size codes.
  localparam logic [1:0] SZ_NONE = 2'd0;
  localparam logic [1:0] SZ_16   = 2'd1;
  localparam logic [1:0] SZ_32   = 2'd2;
  localparam logic [1:0] SZ_64   = 2'd3;

  // Status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_OVF   = 2'd1;
  localparam logic [1:0] ST_UNSUP = 2'd2;

  typedef enum logic [3:0] {
    K_NONE,
    K_DATA,
    K_MOVW,
    K_LD19,
    K_ADR,
    K_ADRP,
    K_LO12,
    K_BR26,
    K_UNSUP
  } job_kind_t;

  // One classified relocation as it travels from the front end to the back end.
  typedef struct packed {
    job_kind_t         kind;
    logic [1:0]        size;
    logic              chk;
    logic              nz;
    logic [1:0]        grp;
    logic [2:0]        scale;
    logic [WORD_W-1:0] x;
    logic [HI_W-1:0]   sa_hi;
    logic [HI_W-1:0]   p_hi;
    logic [INS_W-1:0]  ins;
  } job_t;

endpackage
`default_nettype wire

// ===== rtl/arp_if.sv =====
`default_nettype none
interface arp_in_if
  import arp_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [FUNC_W-1:0]        func;
  logic [WORD_W-1:0]        symbol_value;
  logic signed [WORD_W-1:0] addend;
  logic [WORD_W-1:0]        place_address;
  logic [WORD_W-1:0]        original_word;

  modport source (output valid, func, symbol_value, addend, place_address, original_word,
                  input ready);
  modport sink (input valid, func, symbol_value, addend, place_address, original_word,
                output ready);
endinterface

interface arp_out_if
  import arp_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] patched_word;
  logic [1:0]        write_size;
  logic [1:0]        status;

  modport source (output valid, patched_word, write_size, status, input ready);
  modport sink (input valid, patched_word, write_size, status, output ready);
endinterface
`default_nettype wire

// ===== rtl/arp_front.sv =====
`default_nettype none
module arp_front
  import arp_pkg::*;
(
  arp_in_if.sink in_ch,
  input  logic   q_full,
  output logic   push,
  output job_t   job
);

  logic [WORD_W-1:0] s_v;
  logic [WORD_W-1:0] a_v;
  logic [WORD_W-1:0] np_v;
  logic [WORD_W-1:0] sa;
  logic [WORD_W-1:0] pr;
  logic [WORD_W-1:0] cs_sum;
  logic [WORD_W-1:0] cs_carry;
  logic              use_pr;

  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;

  assign s_v  = in_ch.symbol_value;
  assign a_v  = in_ch.addend;
  assign np_v = ~in_ch.place_address;

  // S + A is one add, and S + A - P uses a carry-save level so that it is also one add deep.
  assign sa       = s_v + a_v;
  assign cs_sum   = s_v ^ a_v ^ np_v;
  assign cs_carry = {((s_v[WORD_W-2:0] & a_v[WORD_W-2:0]) |
                      (s_v[WORD_W-2:0] & np_v[WORD_W-2:0]) |
                      (a_v[WORD_W-2:0] & np_v[WORD_W-2:0])), 1'b0};
  assign pr       = cs_sum + cs_carry + {{(WORD_W-1){1'b0}}, 1'b1};

  always_comb begin
    job.kind  = K_UNSUP;
    job.size  = SZ_NONE;
    job.chk   = 1'b0;
    job.nz    = 1'b0;
    job.grp   = 2'd0;
    job.scale = 3'd0;
    use_pr    = 1'b0;
    unique case (in_ch.func)
      R_NONE:               job.kind = K_NONE;
      R_ABS64:              begin job.kind = K_DATA; job.size = SZ_64; end
      R_ABS32:              begin job.kind = K_DATA; job.size = SZ_32; job.chk = 1'b1; end
      R_ABS16:              begin job.kind = K_DATA; job.size = SZ_16; job.chk = 1'b1; end
      R_PREL64:             begin job.kind = K_DATA; job.size = SZ_64; use_pr = 1'b1; end
      R_PREL32:             begin
        job.kind = K_DATA; job.size = SZ_32; job.chk = 1'b1; use_pr = 1'b1;
      end
      R_PREL16:             begin
        job.kind = K_DATA; job.size = SZ_16; job.chk = 1'b1; use_pr = 1'b1;
      end
      R_MOVW_UABS_G0:       begin job.kind = K_MOVW; job.chk = 1'b1; end
      R_MOVW_UABS_G0_NC:    job.kind = K_MOVW;
      R_MOVW_UABS_G1:       begin job.kind = K_MOVW; job.grp = 2'd1; job.chk = 1'b1; end
      R_MOVW_UABS_G1_NC:    begin job.kind = K_MOVW; job.grp = 2'd1; end
      R_MOVW_UABS_G2:       begin job.kind = K_MOVW; job.grp = 2'd2; job.chk = 1'b1; end
      R_MOVW_UABS_G2_NC:    begin job.kind = K_MOVW; job.grp = 2'd2; end
      R_MOVW_UABS_G3:       begin job.kind = K_MOVW; job.grp = 2'd3; end
      R_MOVW_SABS_G0:       begin job.kind = K_MOVW; job.nz = 1'b1; job.chk = 1'b1; end
      R_MOVW_SABS_G1:       begin
        job.kind = K_MOVW; job.grp = 2'd1; job.nz = 1'b1; job.chk = 1'b1;
      end
      R_MOVW_SABS_G2:       begin
        job.kind = K_MOVW; job.grp = 2'd2; job.nz = 1'b1; job.chk = 1'b1;
      end
      R_LD_PREL_LO19:       begin job.kind = K_LD19; job.chk = 1'b1; use_pr = 1'b1; end
      R_ADR_PREL_LO21:      begin job.kind = K_ADR; job.chk = 1'b1; use_pr = 1'b1; end
      R_ADR_PREL_PG_HI21:   begin job.kind = K_ADRP; job.chk = 1'b1; end
      R_ADR_PREL_PG_HI21NC: job.kind = K_ADRP;
      R_ADD_ABS_LO12_NC,
      R_LDST8_ABS_LO12_NC:  job.kind = K_LO12;
      R_JUMP26,
      R_CALL26:             begin job.kind = K_BR26; job.chk = 1'b1; use_pr = 1'b1; end
      R_LDST16_ABS_LO12_NC: begin job.kind = K_LO12; job.scale = 3'd1; end
      R_LDST32_ABS_LO12_NC: begin job.kind = K_LO12; job.scale = 3'd2; end
      R_LDST64_ABS_LO12_NC: begin job.kind = K_LO12; job.scale = 3'd3; end
      R_LDST128_ABS_LO12_NC: begin job.kind = K_LO12; job.scale = 3'd4; end
      R_MOVW_PREL_G0:       begin
        job.kind = K_MOVW; job.nz = 1'b1; job.chk = 1'b1; use_pr = 1'b1;
      end
      R_MOVW_PREL_G0_NC:    begin job.kind = K_MOVW; use_pr = 1'b1; end
      R_MOVW_PREL_G1:       begin
        job.kind = K_MOVW; job.grp = 2'd1; job.nz = 1'b1; job.chk = 1'b1; use_pr = 1'b1;
      end
      R_MOVW_PREL_G1_NC:    begin job.kind = K_MOVW; job.grp = 2'd1; use_pr = 1'b1; end
      R_MOVW_PREL_G2:       begin
        job.kind = K_MOVW; job.grp = 2'd2; job.nz = 1'b1; job.chk = 1'b1; use_pr = 1'b1;
      end
      R_MOVW_PREL_G2_NC:    begin job.kind = K_MOVW; job.grp = 2'd2; use_pr = 1'b1; end
      R_MOVW_PREL_G3:       begin
        job.kind = K_MOVW; job.grp = 2'd3; job.nz = 1'b1; use_pr = 1'b1;
      end
      default:              job.kind = K_UNSUP;
    endcase
    job.x     = use_pr ? pr : sa;
    job.sa_hi = sa[WORD_W-1:PAGE_W];
    job.p_hi  = in_ch.place_address[WORD_W-1:PAGE_W];
    job.ins   = in_ch.original_word[INS_W-1:0];
  end

endmodule
`default_nettype wire

// ===== rtl/arp_queue.sv =====
`default_nettype none
module arp_queue
  import arp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output logic full,
  output logic head_valid,
  output job_t head_job
);

  job_t               mem [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r;
  logic [Q_PTR_W-1:0] rd_ptr_r;
  logic [Q_CNT_W-1:0] cnt_r;
  logic [Q_PTR_W-1:0] wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_nxt;
  logic [Q_CNT_W-1:0] cnt_nxt;
  logic               do_pop;

  assign full       = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_job   = mem[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_job;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= Q_CNT_W'(Q_DEPTH))
    else $error("queue occupancy above depth");

  a_push_only: assert property (@(posedge clk) disable iff (!rst_n)
    push && !do_pop |=> cnt_r == $past(cnt_r) + 1'b1)
    else $error("occupancy did not grow on a lone push");

  a_pop_only: assert property (@(posedge clk) disable iff (!rst_n)
    !push && do_pop |=> cnt_r == $past(cnt_r) - 1'b1)
    else $error("occupancy did not shrink on a lone pop");
`endif

endmodule
`default_nettype wire

// ===== rtl/arp_back.sv =====
`default_nettype none
module arp_back
  import arp_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    head_valid,
  input  job_t    head_job,
  output logic    pop,
  arp_out_if.source out_ch
);

  logic              out_valid_r;
  logic [WORD_W-1:0] word_r;
  logic [1:0]        size_r;
  logic [1:0]        status_r;

  logic [WORD_W-1:0] x;
  logic [INS_W-1:0]  ins;
  logic [HI_W-1:0]   pg_hi;
  logic [WORD_W-1:0] t;
  logic [15:0]       movw_fld;
  logic              movw_hi;
  logic [11:0]       lo12;
  logic [20:0]       adr_imm;
  logic              ok16;
  logic              ok32;
  logic              ok20;
  logic              ok27;
  logic              okpg;
  logic              ovf;
  logic              is_ins;
  logic [WORD_W-1:0] word_nxt;
  logic [1:0]        size_nxt;
  logic [1:0]        status_nxt;

  assign x     = head_job.x;
  assign pg_hi = head_job.sa_hi - head_job.p_hi;

  // Signed ranges: negative values need all ones above the low bound, positive
  // ones all zeros above the high bound.
  assign ok16 = x[WORD_W-1] ? (&x[WORD_W-1:15]) : !(|x[WORD_W-1:16]);
  assign ok32 = x[WORD_W-1] ? (&x[WORD_W-1:31]) : !(|x[WORD_W-1:32]);
  assign ok20 = (&x[WORD_W-1:20]) || !(|x[WORD_W-1:20]);
  assign ok27 = (&x[WORD_W-1:27]) || !(|x[WORD_W-1:27]);
  assign okpg = (&pg_hi[HI_W-1:20]) || !(|pg_hi[HI_W-1:20]);

  assign t    = (head_job.nz && x[WORD_W-1]) ? ~x : x;
  assign lo12 = x[11:0] >> head_job.scale;

  always_comb begin
    unique case (head_job.grp)
      2'd0:    begin movw_fld = t[15:0];  movw_hi = |t[WORD_W-1:16]; end
      2'd1:    begin movw_fld = t[31:16]; movw_hi = |t[WORD_W-1:32]; end
      2'd2:    begin movw_fld = t[47:32]; movw_hi = |t[WORD_W-1:48]; end
      default: begin movw_fld = t[63:48]; movw_hi = 1'b0; end
    endcase
  end

  assign adr_imm = (head_job.kind == K_ADRP) ? pg_hi[20:0] : x[20:0];

  always_comb begin
    ins        = head_job.ins;
    ovf        = 1'b0;
    is_ins     = 1'b1;
    word_nxt   = '0;
    size_nxt   = SZ_NONE;
    status_nxt = ST_OK;
    unique case (head_job.kind)
      K_NONE: is_ins = 1'b0;
      K_DATA: begin
        is_ins   = 1'b0;
        size_nxt = head_job.size;
        unique case (head_job.size)
          SZ_16: begin
            word_nxt = {{(WORD_W-16){1'b0}}, x[15:0]};
            ovf      = head_job.chk && !ok16;
          end
          SZ_32: begin
            word_nxt = {{(WORD_W-32){1'b0}}, x[31:0]};
            ovf      = head_job.chk && !ok32;
          end
          default: word_nxt = x;
        endcase
      end
      K_MOVW: begin
        if (head_job.nz) begin
          ins[30] = !x[WORD_W-1];
        end
        ins[20:5] = movw_fld;
        ovf       = head_job.chk && movw_hi;
      end
      K_LD19: begin
        ins[23:5] = x[20:2];
        ovf       = !ok20;
      end
      K_ADR: begin
        ins[30:29] = adr_imm[1:0];
        ins[23:5]  = adr_imm[20:2];
        ovf        = !ok20;
      end
      K_ADRP: begin
        ins[30:29] = adr_imm[1:0];
        ins[23:5]  = adr_imm[20:2];
        ovf        = head_job.chk && !okpg;
      end
      K_LO12: ins[21:10] = lo12;
      K_BR26: begin
        ins[25:0] = x[27:2];
        ovf       = !ok27;
      end
      default: begin
        is_ins     = 1'b0;
        status_nxt = ST_UNSUP;
      end
    endcase
    if (is_ins) begin
      word_nxt = {{(WORD_W-INS_W){1'b0}}, ins};
      size_nxt = SZ_32;
    end
    if (ovf) begin
      word_nxt   = '0;
      size_nxt   = SZ_NONE;
      status_nxt = ST_OVF;
    end
  end

  assign pop = head_valid && (!out_valid_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      word_r   <= word_nxt;
      size_r   <= size_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.patched_word = word_r;
  assign out_ch.write_size   = size_r;
  assign out_ch.status       = status_r;

`ifndef SYNTHESIS
  a_ovf_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && status_r == ST_OVF |-> size_r == SZ_NONE && word_r == '0)
    else $error("overflow result carries a write");

  a_unsup_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && status_r == ST_UNSUP |-> size_r == SZ_NONE)
    else $error("unsupported type carries a write");

  a_narrow_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && size_r == SZ_32 |-> word_r[WORD_W-1:32] == '0)
    else $error("32-bit write has upper bits set");
`endif

endmodule
`default_nettype wire

// ===== rtl/aarch64_relocation_patcher_unit.sv =====
// Datapath: each input transfer goes into the queue, then into the result register, which offers it.
// Throughput: one relocation per cycle while the result channel is ready; the patch logic is combinational.
// The input side keeps taking transfers while a result waits, until the two-entry queue is full.
// Reset: synchronous, active low; empties the queue and drops the pending result.
// No memories are cleared after reset, so the block is ready as soon as reset is released.
`default_nettype none
module aarch64_relocation_patcher_unit
  import arp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  arp_in_if.sink      in_ch,
  arp_out_if.source   out_ch
);

  // The front end decodes the relocation type into a job description and forms
  // S+A and S+A-P. The page difference for ADRP is finished in the back end from
  // the upper bits of S+A and P, which keeps each side to about one wide add.
  logic push;
  job_t push_job;
  logic q_full;
  logic head_valid;
  job_t head_job;
  logic pop;

  arp_front u_front (
    .in_ch  (in_ch),
    .q_full (q_full),
    .push   (push),
    .job    (push_job)
  );

  // The queue decouples classification from patching, so a stalled result
  // channel does not stop the input side at once.
  arp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  // The back end performs the range checks, rewrites the immediate field or the
  // datum, and holds the result in an output register until it is transferred.
  arp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

// Block-level test of the AArch64 relocation patcher.
//
// The bench drives relocation records into the input channel and checks every
// result transfer against its own model of the patch logic. Each accepted input
// transfer is run through patch_relocation() on the spot, and the result is
// queued in pending_patches. Each accepted result transfer is compared, field by
// field, against the oldest queued entry. Inputs change on the falling edge, and
// both channels are sampled on the rising edge, so the sampled values are never
// in flight when they are read.
//
// The stimulus starts with short directed groups: data relocations at their
// range edges, the MOVW groups, the PC-relative instruction forms, the LO12
// forms, the none type and unsupported types. After that comes a long random
// stream. Most random records aim S+A or S+A-P near a power of two, so that the
// range checks are hit from both sides. The rest is fully random, and those
// records also toggle every input bit.
module tb_top;
  import arp_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 400;
  localparam int unsigned CYCLE_LIMIT  = 100000;
  localparam int unsigned MAX_REPORTS  = 10;

  // One relocation record as it is driven into the block.
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [WORD_W-1:0] sym;
    logic [WORD_W-1:0] addend;
    logic [WORD_W-1:0] place;
    logic [WORD_W-1:0] orig;
  } reloc_t;

  // The patch that the block must return for a record.
  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [1:0]        size;
    logic [1:0]        status;
  } patch_t;

  logic clk;
  logic rst_n;

  arp_in_if  in_ch ();
  arp_out_if out_ch ();

  aarch64_relocation_patcher_unit DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Every relocation type that the block patches, for the random stream.
  logic [FUNC_W-1:0] known_types [0:35] = '{
    R_NONE, R_ABS64, R_ABS32, R_ABS16, R_PREL64, R_PREL32, R_PREL16,
    R_MOVW_UABS_G0, R_MOVW_UABS_G0_NC, R_MOVW_UABS_G1, R_MOVW_UABS_G1_NC,
    R_MOVW_UABS_G2, R_MOVW_UABS_G2_NC, R_MOVW_UABS_G3,
    R_MOVW_SABS_G0, R_MOVW_SABS_G1, R_MOVW_SABS_G2,
    R_LD_PREL_LO19, R_ADR_PREL_LO21, R_ADR_PREL_PG_HI21, R_ADR_PREL_PG_HI21NC,
    R_ADD_ABS_LO12_NC, R_LDST8_ABS_LO12_NC, R_JUMP26, R_CALL26,
    R_LDST16_ABS_LO12_NC, R_LDST32_ABS_LO12_NC, R_LDST64_ABS_LO12_NC,
    R_MOVW_PREL_G0, R_MOVW_PREL_G0_NC, R_MOVW_PREL_G1, R_MOVW_PREL_G1_NC,
    R_MOVW_PREL_G2, R_MOVW_PREL_G2_NC, R_MOVW_PREL_G3, R_LDST128_ABS_LO12_NC
  };

  patch_t      pending_patches [$];
  int unsigned error_count;
  int unsigned cycle_count;
  int          burst_left;
  logic        sender_gaps_on;
  logic        sink_stalls_on;

  // The clock has a 4 ns period.
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // ------------------------------------------------------------------------
  // Patch model
  // ------------------------------------------------------------------------

  // True when x, read as two's complement, lies in -2^lo .. 2^hi - 1.
  function automatic logic in_range(input logic [63:0] x, input int unsigned lo,
                                    input int unsigned hi);
    if (x[63]) return (~x) < (64'd1 << lo);
    return x < (64'd1 << hi);
  endfunction

  // Writes one 16-bit MOVW group into imm16. The signed forms turn a negative
  // value into MOVN with the inverted value, and a positive value into MOVZ.
  function automatic logic [31:0] movw_patch(input logic [31:0] ins, input logic [63:0] x,
                                             input int unsigned shift, input logic signed_form,
                                             input logic checked, output logic ovf);
    logic [63:0] t;
    logic [63:0] grp;
    t = x;
    if (signed_form) begin
      if (x[63]) begin
        t = ~x;
        ins[30] = 1'b0;
      end else begin
        ins[30] = 1'b1;
      end
    end
    grp = t >> shift;
    ovf = checked && ((grp >> 16) != 64'd0);
    ins[20:5] = grp[15:0];
    return ins;
  endfunction

  // Splits an ADR or ADRP immediate into immlo (30:29) and immhi (23:5).
  function automatic logic [31:0] adr_patch(input logic [31:0] ins, input logic [63:0] imm);
    ins[30:29] = imm[1:0];
    ins[23:5]  = imm[20:2];
    return ins;
  endfunction

  // LO12 forms: the 12-bit field at 21:10 takes bits 11:scale of the value.
  function automatic logic [31:0] lo12_patch(input logic [31:0] ins, input logic [63:0] x,
                                             input int unsigned scale);
    logic [11:0] imm;
    imm = x[11:0] >> scale;
    ins[21:10] = imm;
    return ins;
  endfunction

  function automatic patch_t patch_relocation(input reloc_t r);
    logic [63:0] sa;
    logic [63:0] pr;
    logic [63:0] pg;
    logic [31:0] ins;
    logic        ovf;
    logic        is_ins;
    patch_t      res;
    sa     = r.sym + r.addend;
    pr     = sa - r.place;
    pg     = (sa & ~64'hfff) - (r.place & ~64'hfff);
    ins    = r.orig[31:0];
    ovf    = 1'b0;
    is_ins = 1'b1;
    res    = '{word: '0, size: SZ_NONE, status: ST_OK};
    case (r.func)
      R_NONE: is_ins = 1'b0;
      R_ABS64: begin
        res.word = sa;
        res.size = SZ_64;
        is_ins   = 1'b0;
      end
      R_ABS32: begin
        ovf      = !in_range(sa, 31, 32);
        res.word = {32'd0, sa[31:0]};
        res.size = SZ_32;
        is_ins   = 1'b0;
      end
      R_ABS16: begin
        ovf      = !in_range(sa, 15, 16);
        res.word = {48'd0, sa[15:0]};
        res.size = SZ_16;
        is_ins   = 1'b0;
      end
      R_PREL64: begin
        res.word = pr;
        res.size = SZ_64;
        is_ins   = 1'b0;
      end
      R_PREL32: begin
        ovf      = !in_range(pr, 31, 32);
        res.word = {32'd0, pr[31:0]};
        res.size = SZ_32;
        is_ins   = 1'b0;
      end
      R_PREL16: begin
        ovf      = !in_range(pr, 15, 16);
        res.word = {48'd0, pr[15:0]};
        res.size = SZ_16;
        is_ins   = 1'b0;
      end
      R_MOVW_UABS_G0:    ins = movw_patch(ins, sa, 0, 1'b0, 1'b1, ovf);
      R_MOVW_UABS_G0_NC: ins = movw_patch(ins, sa, 0, 1'b0, 1'b0, ovf);
      R_MOVW_UABS_G1:    ins = movw_patch(ins, sa, 16, 1'b0, 1'b1, ovf);
      R_MOVW_UABS_G1_NC: ins = movw_patch(ins, sa, 16, 1'b0, 1'b0, ovf);
      R_MOVW_UABS_G2:    ins = movw_patch(ins, sa, 32, 1'b0, 1'b1, ovf);
      R_MOVW_UABS_G2_NC: ins = movw_patch(ins, sa, 32, 1'b0, 1'b0, ovf);
      R_MOVW_UABS_G3:    ins = movw_patch(ins, sa, 48, 1'b0, 1'b0, ovf);
      R_MOVW_SABS_G0:    ins = movw_patch(ins, sa, 0, 1'b1, 1'b1, ovf);
      R_MOVW_SABS_G1:    ins = movw_patch(ins, sa, 16, 1'b1, 1'b1, ovf);
      R_MOVW_SABS_G2:    ins = movw_patch(ins, sa, 32, 1'b1, 1'b1, ovf);
      R_LD_PREL_LO19: begin
        ovf       = !in_range(pr, 20, 20);
        ins[23:5] = pr[20:2];
      end
      R_ADR_PREL_LO21: begin
        ovf = !in_range(pr, 20, 20);
        ins = adr_patch(ins, pr);
      end
      R_ADR_PREL_PG_HI21: begin
        ovf = !in_range(pg, 32, 32);
        ins = adr_patch(ins, pg >> 12);
      end
      R_ADR_PREL_PG_HI21NC:  ins = adr_patch(ins, pg >> 12);
      R_ADD_ABS_LO12_NC:     ins = lo12_patch(ins, sa, 0);
      R_LDST8_ABS_LO12_NC:   ins = lo12_patch(ins, sa, 0);
      R_LDST16_ABS_LO12_NC:  ins = lo12_patch(ins, sa, 1);
      R_LDST32_ABS_LO12_NC:  ins = lo12_patch(ins, sa, 2);
      R_LDST64_ABS_LO12_NC:  ins = lo12_patch(ins, sa, 3);
      R_LDST128_ABS_LO12_NC: ins = lo12_patch(ins, sa, 4);
      R_JUMP26, R_CALL26: begin
        ovf       = !in_range(pr, 27, 27);
        ins[25:0] = pr[27:2];
      end
      R_MOVW_PREL_G0:    ins = movw_patch(ins, pr, 0, 1'b1, 1'b1, ovf);
      R_MOVW_PREL_G0_NC: ins = movw_patch(ins, pr, 0, 1'b0, 1'b0, ovf);
      R_MOVW_PREL_G1:    ins = movw_patch(ins, pr, 16, 1'b1, 1'b1, ovf);
      R_MOVW_PREL_G1_NC: ins = movw_patch(ins, pr, 16, 1'b0, 1'b0, ovf);
      R_MOVW_PREL_G2:    ins = movw_patch(ins, pr, 32, 1'b1, 1'b1, ovf);
      R_MOVW_PREL_G2_NC: ins = movw_patch(ins, pr, 32, 1'b0, 1'b0, ovf);
      // G3 has a signed form but no range check.
      R_MOVW_PREL_G3:    ins = movw_patch(ins, pr, 48, 1'b1, 1'b0, ovf);
      default: begin
        res.status = ST_UNSUP;
        is_ins     = 1'b0;
      end
    endcase
    if (is_ins) begin
      res.word = {32'd0, ins};
      res.size = SZ_32;
    end
    // An out-of-range value suppresses the write completely.
    if (ovf) begin
      res = '{word: '0, size: SZ_NONE, status: ST_OVF};
    end
    return res;
  endfunction

  // ------------------------------------------------------------------------
  // Scoreboard
  // ------------------------------------------------------------------------

  task automatic log_error(input string what, input patch_t got, input patch_t want);
    error_count++;
    if (error_count <= MAX_REPORTS) begin
      $display("ERROR %0t: %s: got word %h size %0d status %0d, %s %h size %0d status %0d",
               $realtime, what, got.word, got.size, got.status, "expected word",
               want.word, want.size, want.status);
    end
  endtask

  // The model runs on each input transfer, and each result transfer is checked
  // against the oldest pending patch. The push comes before the pop, so the
  // check holds even if a result were to come out in the cycle of its input.
  always @(posedge clk) begin : scoreboard
    reloc_t rec;
    patch_t got;
    patch_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        rec = '{in_ch.func, in_ch.symbol_value, in_ch.addend, in_ch.place_address,
                in_ch.original_word};
        pending_patches.push_back(patch_relocation(rec));
      end
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.patched_word, out_ch.write_size, out_ch.status};
        if (pending_patches.size() == 0) begin
          log_error("result with no patch pending", got, '0);
        end else begin
          want = pending_patches.pop_front();
          if (got.word !== want.word || got.size !== want.size ||
              got.status !== want.status) begin
            log_error("patch mismatch", got, want);
          end
        end
      end
    end
  end

  // The watchdog ends the run if the block hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("aarch64_relocation_patcher_unit regression: fail");
      $finish;
    end
  end

  // ------------------------------------------------------------------------
  // Channel drivers
  // ------------------------------------------------------------------------

  // The result side holds ready at one level for a random run of cycles and
  // then flips it. When stalls are off, ready stays high.
  initial begin : sink_pattern
    int hold;
    hold = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!sink_stalls_on) begin
        out_ch.ready <= 1'b1;
        hold = 0;
      end else if (hold > 0) begin
        hold--;
      end else if (out_ch.ready) begin
        out_ch.ready <= 1'b0;
        hold = $urandom_range(0, 5);
      end else begin
        out_ch.ready <= 1'b1;
        hold = $urandom_range(0, 9);
      end
    end
  end

  // Sends one record and returns after its transfer. With gaps on, the sender
  // works in bursts of random length, and valid drops for a random number of
  // cycles between bursts. Without a gap, valid stays high from one record to
  // the next, and only the payload changes.
  task automatic send_reloc(input reloc_t r);
    @(negedge clk);
    if (sender_gaps_on && burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    if (burst_left > 0) burst_left--;
    in_ch.valid         <= 1'b1;
    in_ch.func          <= r.func;
    in_ch.symbol_value  <= r.sym;
    in_ch.addend        <= r.addend;
    in_ch.place_address <= r.place;
    in_ch.original_word <= r.orig;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Lowers valid and holds off until every pending patch has come back.
  task automatic wait_for_patches();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_patches.size() != 0) @(posedge clk);
  endtask

  function automatic reloc_t make_reloc(input logic [FUNC_W-1:0] func,
                                        input logic [63:0] sym, input logic [63:0] addend,
                                        input logic [63:0] place, input logic [63:0] orig);
    return '{func, sym, addend, place, orig};
  endfunction

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // A value a few units away from +/- 2^k. The range checks switch at these
  // values.
  function automatic logic [63:0] rand_edge_value();
    logic [63:0] v;
    logic [63:0] jitter;
    jitter = 64'($urandom_range(0, 8));
    v = (64'd1 << $urandom_range(0, 40)) + jitter - 64'd4;
    if ($urandom_range(0, 1)) v = -v;
    return v;
  endfunction

  function automatic reloc_t rand_reloc();
    reloc_t      r;
    logic [63:0] v;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 85) r.func = known_types[6'($urandom_range(0, 35))];
    else if (pick < 95) r.func = FUNC_W'($urandom_range(0, 1023));
    else r.func = FUNC_W'($urandom_range(279, 281));
    r.orig  = $urandom_range(0, 3) == 0 ? {32'd0, $urandom} : rand_word();
    r.place = rand_word();
    r.sym   = $urandom_range(0, 3) == 0 ? 64'd0 : rand_word();
    v       = rand_edge_value();
    case ($urandom_range(0, 3))
      0: r.addend = rand_word();                // anything at all
      1: r.addend = v - r.sym;                  // S+A near an edge
      default: r.addend = v + r.place - r.sym;  // S+A-P near an edge
    endcase
    return r;
  endfunction

  // ------------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------------

  // Data relocations: full-width values and the edges of the 16- and 32-bit
  // ranges.
  task automatic test_data_relocs();
    send_reloc(make_reloc(R_ABS64, '1, 64'h8000_0000_0000_0000, '0, '1));
    send_reloc(make_reloc(R_ABS32, '0, 64'h0000_0000_ffff_ffff, '0, '0));
    send_reloc(make_reloc(R_ABS32, 64'h0000_0001_0000_0000, '0, '0, '1));
    send_reloc(make_reloc(R_ABS32, '0, 64'hffff_ffff_8000_0000, '1, '0));
    send_reloc(make_reloc(R_ABS16, '0, 64'hffff_ffff_ffff_7fff, '0, '0));
    send_reloc(make_reloc(R_PREL16, 64'h1_ffff, '0, 64'h1_0000, '1));
    send_reloc(make_reloc(R_PREL32, '0, '0, 64'd1, '0));
    send_reloc(make_reloc(R_PREL64, '0, 64'h7fff_ffff_ffff_ffff, '1, '1));
  endtask

  // MOVW groups: unsigned overflow, the top group, and the signed forms that
  // turn a negative value into MOVN.
  task automatic test_movw_groups();
    send_reloc(make_reloc(R_MOVW_UABS_G0, 64'h1_0000, '0, '0, 64'hd280_0000));
    send_reloc(make_reloc(R_MOVW_UABS_G1, 64'hffff_ffff, '0, '0, 64'hf2a0_0000));
    send_reloc(make_reloc(R_MOVW_UABS_G3, '1, '0, '0, 64'hd2e0_0000));
    send_reloc(make_reloc(R_MOVW_SABS_G1, '0, -64'h1_2345, '0, 64'hd2a0_0000));
    send_reloc(make_reloc(R_MOVW_PREL_G3, '0, '0, 64'd1, 64'h92e0_0000));
    send_reloc(make_reloc(R_MOVW_PREL_G2, 64'h0001_0000_0000_0000, '0, '0, '1));
  endtask

  // PC-relative instruction forms at the edges of their ranges.
  task automatic test_pc_relative();
    send_reloc(make_reloc(R_LD_PREL_LO19, 64'hf_fffc, '0, '0, 64'h5800_0000));
    send_reloc(make_reloc(R_LD_PREL_LO19, '0, '0, 64'h10_0001, 64'h5800_0000));
    send_reloc(make_reloc(R_ADR_PREL_LO21, '0, '0, 64'h10_0000, 64'h1000_0000));
    send_reloc(make_reloc(R_ADR_PREL_PG_HI21, 64'h1_0000_0000, '0, '0, 64'h9000_0000));
    send_reloc(make_reloc(R_ADR_PREL_PG_HI21NC, 64'h1_0000_0000, '0, '0, 64'h9000_0000));
    send_reloc(make_reloc(R_JUMP26, 64'h7ff_fffc, '0, '0, 64'h1400_0000));
    send_reloc(make_reloc(R_CALL26, '0, '0, 64'h800_0004, 64'h9400_0000));
  endtask

  // The LO12 forms, the none type and types that the block does not handle.
  task automatic test_lo12_and_other_types();
    send_reloc(make_reloc(R_ADD_ABS_LO12_NC, 64'hfff, '0, '0, '1));
    send_reloc(make_reloc(R_LDST128_ABS_LO12_NC, 64'habc, '0, '0, 64'h3dc0_0000));
    send_reloc(make_reloc(R_NONE, '1, '1, '1, '1));
    send_reloc(make_reloc(10'd1023, '1, '1, '1, '1));
    send_reloc(make_reloc(10'd279, '0, '0, '0, '0));
  endtask

  // The random stream runs in four phases, one for each combination of sender
  // gaps and receiver stalls. The sender holds off until all patches are back
  // between phases.
  task automatic test_random_stream();
    for (int phase = 0; phase < 4; phase++) begin
      sender_gaps_on = phase[0];
      sink_stalls_on = phase[1];
      for (int unsigned n = 0; n < RANDOM_ITEMS / 4; n++) send_reloc(rand_reloc());
      wait_for_patches();
    end
  endtask

  initial begin
    error_count         = 0;
    cycle_count         = 0;
    burst_left          = 0;
    sender_gaps_on      = 1'b1;
    sink_stalls_on      = 1'b1;
    in_ch.valid         = 1'b0;
    in_ch.func          = '0;
    in_ch.symbol_value  = '0;
    in_ch.addend        = '0;
    in_ch.place_address = '0;
    in_ch.original_word = '0;
    rst_n               = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_data_relocs();
    test_movw_groups();
    wait_for_patches();
    test_pc_relative();
    test_lo12_and_other_types();
    wait_for_patches();
    test_random_stream();

    // After the last patch is back, the bench waits on to see whether any stray result comes out.
    wait_for_patches();
    repeat (8) @(posedge clk);
    if (error_count == 0 && pending_patches.size() == 0) begin
      $display("aarch64_relocation_patcher_unit regression: pass");
    end else begin
      $display("aarch64_relocation_patcher_unit regression: fail");
    end
    $finish;
  end

endmodule
